// ===== rtl/core/tjlik_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the leg inverse kinematics solver.
package tjlik_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int ANG_W        = 28;
	localparam int ANG_W1       = ANG_W + 1;
	localparam int CW           = 62;
	localparam int RW           = 34;
	localparam int SQ_W         = 60;
	localparam int ROOT_W       = SQ_W / 2;
	localparam int MW           = 32;
	localparam int PW           = 2 * MW;
	localparam int CFG_W        = 16;
	localparam int CIDX_W       = 3;

	localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(1474560);
	localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(2949120);

	typedef enum logic [CIDX_W-1:0] {
		REG_HIP_OFFSET  = 3'd0,
		REG_FEMUR_LEN   = 3'd1,
		REG_TIBIA_LEN   = 3'd2,
		REG_TIBIA_OFS   = 3'd3,
		REG_HIP_CENTER  = 3'd4,
		REG_FEMUR_CENTER = 3'd5,
		REG_TIBIA_CENTER = 3'd6,
		REG_LEG_CORNER  = 3'd7
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MUL_YY, ST_MUL_ZZ, ST_MUL_LL, ST_MUL_XX, ST_CHECK, ST_G2,
		ST_SQ_DS, ST_AT_YZ, ST_AT_HIP, ST_MUL_RR, ST_MUL_L22, ST_MUL_L33,
		ST_MUL_L23, ST_CLAMP, ST_ND, ST_SQ_A, ST_SQ_B, ST_AT_KNEE, ST_AT_ALPHA,
		ST_MUL_SS, ST_AT_BETA, ST_T2, ST_THS, ST_OUT
	} seq_st_t;

	typedef enum logic [1:0] {
		C_IDLE, C_PREP, C_NORM, C_ROT
	} cor_st_t;

	// atan(2^-i) in 1/16384 degree
	function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] idx);
		logic signed [ANG_W-1:0] a;
		case (idx)
			5'd0:  a = ANG_W'(737280);
			5'd1:  a = ANG_W'(435242);
			5'd2:  a = ANG_W'(229970);
			5'd3:  a = ANG_W'(116736);
			5'd4:  a = ANG_W'(58595);
			5'd5:  a = ANG_W'(29326);
			5'd6:  a = ANG_W'(14667);
			5'd7:  a = ANG_W'(7334);
			5'd8:  a = ANG_W'(3667);
			5'd9:  a = ANG_W'(1833);
			5'd10: a = ANG_W'(917);
			5'd11: a = ANG_W'(458);
			5'd12: a = ANG_W'(229);
			5'd13: a = ANG_W'(115);
			5'd14: a = ANG_W'(57);
			5'd15: a = ANG_W'(29);
			5'd16: a = ANG_W'(14);
			5'd17: a = ANG_W'(7);
			5'd18: a = ANG_W'(4);
			5'd19: a = ANG_W'(2);
			5'd20: a = ANG_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

	// round half up to 1/64 degree and saturate to 16 bits
	function automatic logic signed [15:0] to_out(input logic signed [ANG_W-1:0] v);
		logic signed [ANG_W1-1:0] s;
		logic signed [ANG_W1-9:0] r;
		logic signed [15:0] o;
		s = ANG_W1'(v) + ANG_W1'(128);
		r = s[ANG_W1-1:8];
		if (r > 32767)
			o = 16'sh7fff;
		else if (r < -32768)
			o = 16'sh8000;
		else
			o = r[15:0];
		return o;
	endfunction

endpackage

// ===== rtl/core/tjlik_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
module tjlik_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [tjlik_pkg::MW-1:0]   a,
	input  logic signed [tjlik_pkg::MW-1:0]   b,
	output logic                              done,
	output logic signed [tjlik_pkg::PW-1:0]   prod
);

	logic signed [tjlik_pkg::PW-1:0] prod_q;
	logic                            done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= a * b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	assign prod = prod_q;
	assign done = done_q;

endmodule

// ===== rtl/core/tjlik_sqrt.sv =====
`timescale 1ns / 1ps
// Digit-by-digit floor square root, one result bit per cycle.
module tjlik_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tjlik_pkg::SQ_W-1:0]        rad,
	output logic                              done,
	output logic [tjlik_pkg::ROOT_W-1:0]      root
);

	localparam int SQ_W = tjlik_pkg::SQ_W;

	logic [SQ_W-1:0] v_q, r_q, bit_q;
	logic [SQ_W-1:0] trial;
	logic            busy_q, done_q;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= rad;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && bit_q[0];
			if (start)
				busy_q <= 1'b1;
			else if (busy_q && bit_q[0])
				busy_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign root = r_q[tjlik_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/core/tjlik_cordic.sv =====
`timescale 1ns / 1ps
// Vectoring CORDIC atan2 with operand normalization, one step per cycle.
module tjlik_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [tjlik_pkg::CW-1:0]   y_in,
	input  logic signed [tjlik_pkg::CW-1:0]   x_in,
	output logic                              done,
	output logic signed [tjlik_pkg::ANG_W-1:0] angle
);

	localparam int CW     = tjlik_pkg::CW;
	localparam int RW     = tjlik_pkg::RW;
	localparam int ANG_W  = tjlik_pkg::ANG_W;
	localparam int STEP_W = tjlik_pkg::STEP_W;
	localparam logic [STEP_W-1:0] LAST = STEP_W'(tjlik_pkg::CORDIC_STEPS - 1);

	tjlik_pkg::cor_st_t cst_q, cst_d;

	logic signed [CW-1:0]    yn_q, xn_q;
	logic [CW-1:0]           m_q, mag_y, mag_x;
	logic signed [RW-1:0]    yr_q, xr_q, ys, xs, dx, dy;
	logic signed [ANG_W-1:0] zr_q, z_nxt, res_q;
	logic [STEP_W-1:0]       i_q;
	logic                    is_zero, hi, lo, last, finish, done_q;

	assign is_zero = (yn_q == '0) && (xn_q == '0);
	assign mag_y   = yn_q[CW-1] ? CW'(-yn_q) : CW'(yn_q);
	assign mag_x   = xn_q[CW-1] ? CW'(-xn_q) : CW'(xn_q);
	assign hi      = |m_q[CW-1:30];
	assign lo      = ~|m_q[CW-1:29];
	assign last    = (i_q == LAST);
	assign ys      = yn_q[RW-1:0];
	assign xs      = xn_q[RW-1:0];
	assign dx      = yr_q >>> i_q;
	assign dy      = xr_q >>> i_q;
	assign z_nxt   = (yr_q > 0) ? zr_q + tjlik_pkg::atan_lut(5'(i_q))
	                            : zr_q - tjlik_pkg::atan_lut(5'(i_q));

	always_comb begin
		cst_d = cst_q;
		unique case (cst_q)
			tjlik_pkg::C_IDLE: if (start) cst_d = tjlik_pkg::C_PREP;
			tjlik_pkg::C_PREP: cst_d = is_zero ? tjlik_pkg::C_IDLE : tjlik_pkg::C_NORM;
			tjlik_pkg::C_NORM: if (!hi && !lo) cst_d = tjlik_pkg::C_ROT;
			tjlik_pkg::C_ROT:  if (last) cst_d = tjlik_pkg::C_IDLE;
			default:           cst_d = tjlik_pkg::C_IDLE;
		endcase
	end

	always_comb begin
		finish = 1'b0;
		unique case (cst_q)
			tjlik_pkg::C_PREP: finish = is_zero;
			tjlik_pkg::C_ROT:  finish = last;
			default:           finish = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cst_q)
			tjlik_pkg::C_IDLE: begin
				if (start) begin
					yn_q <= y_in;
					xn_q <= x_in;
				end
			end
			tjlik_pkg::C_PREP: begin
				m_q <= (mag_y > mag_x) ? mag_y : mag_x;
				if (is_zero)
					res_q <= '0;
			end
			tjlik_pkg::C_NORM: begin
				if (hi) begin
					yn_q <= yn_q >>> 1;
					xn_q <= xn_q >>> 1;
					m_q  <= m_q >> 1;
				end else if (lo) begin
					yn_q <= yn_q <<< 1;
					xn_q <= xn_q <<< 1;
					m_q  <= m_q << 1;
				end else begin
					i_q <= '0;
					// pre-rotate the left half-plane by a quarter turn
					if (xs < 0) begin
						if (ys >= 0) begin
							xr_q <= ys;
							yr_q <= -xs;
							zr_q <= tjlik_pkg::DEG90;
						end else begin
							xr_q <= -ys;
							yr_q <= xs;
							zr_q <= -tjlik_pkg::DEG90;
						end
					end else begin
						xr_q <= xs;
						yr_q <= ys;
						zr_q <= '0;
					end
				end
			end
			tjlik_pkg::C_ROT: begin
				if (yr_q > 0) begin
					xr_q <= xr_q + dx;
					yr_q <= yr_q - dy;
				end else begin
					xr_q <= xr_q - dx;
					yr_q <= yr_q + dy;
				end
				zr_q <= z_nxt;
				i_q  <= i_q + 1'b1;
				if (last)
					res_q <= z_nxt;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q  <= tjlik_pkg::C_IDLE;
			done_q <= 1'b0;
		end else begin
			cst_q  <= cst_d;
			done_q <= finish;
		end
	end

	assign done  = done_q;
	assign angle = res_q;

endmodule

// ===== rtl/core/three_joint_leg_inverse_kinematics.sv =====
`timescale 1ns / 1ps
// Three-joint leg inverse kinematics: one foot target in, one set of servo and joint angles
// out. A small sequencer drives one shared multiplier, one bit-serial square root and one
// vectoring CORDIC; the time per item is set mostly by up to five CORDIC passes (one
// normalize shift per cycle, then 16 micro-rotations) and three square roots. An
// unreachable hip goes straight from the check to the output state, with solution_valid
// low and the previous angles. in_ready is high only between items; the result stays in
// the output register until taken, and the next target may be sent meanwhile.
module three_joint_leg_inverse_kinematics (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] target_x,
	input  logic signed [15:0] target_y,
	input  logic signed [15:0] target_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               solution_valid,
	output logic signed [15:0] hip_servo_angle,
	output logic signed [15:0] femur_servo_angle,
	output logic signed [15:0] tibia_servo_angle,
	output logic signed [15:0] hip_joint_angle,
	output logic signed [15:0] femur_joint_angle,
	output logic signed [15:0] tibia_joint_angle
);

	localparam int ANG_W  = tjlik_pkg::ANG_W;
	localparam int CW     = tjlik_pkg::CW;
	localparam int MW     = tjlik_pkg::MW;
	localparam int PW     = tjlik_pkg::PW;
	localparam int SQ_W   = tjlik_pkg::SQ_W;
	localparam int ROOT_W = tjlik_pkg::ROOT_W;

	// configuration
	logic [13:0]        hip_ofs_q, femur_len_q, tibia_len_q;
	logic signed [14:0] tibia_ofs_q;
	logic [14:0]        hip_cen_q, femur_cen_q, tibia_cen_q;
	logic [1:0]         corner_q;

	// sequencer
	tjlik_pkg::seq_st_t st_q, st_d;
	logic iss_q;
	logic mul_start, sq_start, cor_start;
	logic mul_done, sq_done, cor_done;
	logic signed [MW-1:0]    mul_a, mul_b;
	logic signed [PW-1:0]    prod;
	logic [SQ_W-1:0]         sq_rad;
	logic [ROOT_W-1:0]       root;
	logic signed [CW-1:0]    cor_y, cor_x;
	logic signed [ANG_W-1:0] cor_ang;

	// datapath registers
	logic signed [15:0]      x_q, y_q, z_q;
	logic [30:0]             yy_q, zz_q, xx_q;
	logic [27:0]             ll_q;
	logic signed [32:0]      term1_q;
	logic [37:0]             g2_q;
	logic [27:0]             ds_q;
	logic signed [ANG_W-1:0] a1_q, t1_q, t3_q, alpha_q, beta_q, t2_q, ths_q;
	logic [35:0]             rr_q;
	logic [33:0]             l22_q, l33_q, l23_q;
	logic signed [35:0]      n_q;
	logic [34:0]             d_q;
	logic [ROOT_W-1:0]       sa_q, sb_q;
	logic [CW-1:0]           ss_q;
	logic                    ok_q, sol_q, out_valid_q;
	logic signed [15:0]      hs_srv_q, fm_srv_q, tb_srv_q, hs_jnt_q, fm_jnt_q, tb_jnt_q;

	// combinational helpers
	logic [16:0]             l2, l3;
	logic [14:0]             len_sum;
	logic [17:0]             r5, reach;
	logic signed [18:0]      reach_raw;
	logic signed [32:0]      term1_c;
	logic [32:0]             gs;
	logic [37:0]             g2_c;
	logic signed [38:0]      n_raw, w_raw, d_s;
	logic [35:0]             w_abs;
	logic signed [36:0]      dmn, dpn;
	logic                    left, front, out_fire;
	logic signed [ANG_W-1:0] hs, cen_h, cen_f, cen_t, ofs256;

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == tjlik_pkg::ST_IDLE);

	assign l2        = 17'({femur_len_q, 2'b00}) + 17'(femur_len_q);
	assign l3        = 17'({tibia_len_q, 2'b00}) + 17'(tibia_len_q);
	assign len_sum   = 15'(femur_len_q) + 15'(tibia_len_q);
	assign r5        = 18'({len_sum, 2'b00}) + 18'(len_sum);
	assign reach_raw = $signed({1'b0, r5}) - 19'sd8;
	assign reach     = (reach_raw < 19'sd1) ? 18'd1 : reach_raw[17:0];

	assign term1_c = $signed(33'(yy_q) + 33'(zz_q)) - $signed(33'(ll_q));
	assign gs      = 33'(term1_q[31:0]) + 33'(xx_q);
	assign g2_c    = 38'({gs, 4'b0}) + 38'({gs, 3'b0}) + 38'(gs);
	assign n_raw   = $signed(39'(l22_q)) + $signed(39'(l33_q)) - $signed(39'(g2_q));
	assign d_s     = $signed(39'({l23_q, 1'b0}));
	assign w_raw   = $signed(39'(l22_q)) + $signed(39'(g2_q)) - $signed(39'(l33_q));
	assign w_abs   = w_raw[38] ? 36'(-w_raw) : 36'(w_raw);
	assign dmn     = $signed(37'(d_q)) - 37'(n_q);
	assign dpn     = $signed(37'(d_q)) + 37'(n_q);

	assign left   = corner_q[1];
	assign front  = corner_q[0];
	assign hs     = (left == front) ? t1_q : -t1_q;
	assign cen_h  = ANG_W'({hip_cen_q, 8'b0});
	assign cen_f  = ANG_W'({femur_cen_q, 8'b0});
	assign cen_t  = ANG_W'({tibia_cen_q, 8'b0});
	assign ofs256 = ANG_W'(tibia_ofs_q) <<< 8;
	assign out_fire = (st_q == tjlik_pkg::ST_OUT) && (!out_valid_q || out_ready);

	tjlik_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(prod)
	);

	tjlik_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .rad(sq_rad),
		.done(sq_done), .root(root)
	);

	tjlik_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .y_in(cor_y), .x_in(cor_x),
		.done(cor_done), .angle(cor_ang)
	);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			tjlik_pkg::ST_IDLE:     if (in_valid) st_d = tjlik_pkg::ST_MUL_YY;
			tjlik_pkg::ST_MUL_YY:   if (mul_done) st_d = tjlik_pkg::ST_MUL_ZZ;
			tjlik_pkg::ST_MUL_ZZ:   if (mul_done) st_d = tjlik_pkg::ST_MUL_LL;
			tjlik_pkg::ST_MUL_LL:   if (mul_done) st_d = tjlik_pkg::ST_MUL_XX;
			tjlik_pkg::ST_MUL_XX:   if (mul_done) st_d = tjlik_pkg::ST_CHECK;
			tjlik_pkg::ST_CHECK:    st_d = term1_c[32] ? tjlik_pkg::ST_OUT : tjlik_pkg::ST_G2;
			tjlik_pkg::ST_G2:       st_d = tjlik_pkg::ST_SQ_DS;
			tjlik_pkg::ST_SQ_DS:    if (sq_done) st_d = tjlik_pkg::ST_AT_YZ;
			tjlik_pkg::ST_AT_YZ:    if (cor_done) st_d = tjlik_pkg::ST_AT_HIP;
			tjlik_pkg::ST_AT_HIP:   if (cor_done) st_d = tjlik_pkg::ST_MUL_RR;
			tjlik_pkg::ST_MUL_RR:   if (mul_done) st_d = tjlik_pkg::ST_MUL_L22;
			tjlik_pkg::ST_MUL_L22:  if (mul_done) st_d = tjlik_pkg::ST_MUL_L33;
			tjlik_pkg::ST_MUL_L33:  if (mul_done) st_d = tjlik_pkg::ST_MUL_L23;
			tjlik_pkg::ST_MUL_L23:  if (mul_done) st_d = tjlik_pkg::ST_CLAMP;
			tjlik_pkg::ST_CLAMP:    st_d = tjlik_pkg::ST_ND;
			tjlik_pkg::ST_ND:       st_d = tjlik_pkg::ST_SQ_A;
			tjlik_pkg::ST_SQ_A:     if (sq_done) st_d = tjlik_pkg::ST_SQ_B;
			tjlik_pkg::ST_SQ_B:     if (sq_done) st_d = tjlik_pkg::ST_AT_KNEE;
			tjlik_pkg::ST_AT_KNEE:  if (cor_done) st_d = tjlik_pkg::ST_AT_ALPHA;
			tjlik_pkg::ST_AT_ALPHA: if (cor_done) st_d = tjlik_pkg::ST_MUL_SS;
			tjlik_pkg::ST_MUL_SS: begin
				if (g2_q == '0)
					st_d = tjlik_pkg::ST_T2;
				else if (mul_done)
					st_d = tjlik_pkg::ST_AT_BETA;
			end
			tjlik_pkg::ST_AT_BETA:  if (cor_done) st_d = tjlik_pkg::ST_T2;
			tjlik_pkg::ST_T2:       st_d = tjlik_pkg::ST_THS;
			tjlik_pkg::ST_THS:      st_d = tjlik_pkg::ST_OUT;
			tjlik_pkg::ST_OUT:      if (!out_valid_q || out_ready) st_d = tjlik_pkg::ST_IDLE;
			default:                st_d = tjlik_pkg::ST_IDLE;
		endcase
	end

	// unit commands and operands
	always_comb begin
		mul_start = 1'b0;
		sq_start  = 1'b0;
		cor_start = 1'b0;
		mul_a     = MW'(y_q);
		mul_b     = MW'(y_q);
		sq_rad    = SQ_W'({term1_q[31:0], 24'b0});
		cor_y     = CW'(y_q);
		cor_x     = CW'(z_q);
		unique case (st_q)
			tjlik_pkg::ST_MUL_YY: begin
				mul_start = !iss_q;
			end
			tjlik_pkg::ST_MUL_ZZ: begin
				mul_start = !iss_q;
				mul_a = MW'(z_q);
				mul_b = MW'(z_q);
			end
			tjlik_pkg::ST_MUL_LL: begin
				mul_start = !iss_q;
				mul_a = MW'(hip_ofs_q);
				mul_b = MW'(hip_ofs_q);
			end
			tjlik_pkg::ST_MUL_XX: begin
				mul_start = !iss_q;
				mul_a = MW'(x_q);
				mul_b = MW'(x_q);
			end
			tjlik_pkg::ST_SQ_DS: begin
				sq_start = !iss_q;
			end
			tjlik_pkg::ST_AT_YZ: begin
				cor_start = !iss_q;
			end
			tjlik_pkg::ST_AT_HIP: begin
				cor_start = !iss_q;
				cor_y = CW'({hip_ofs_q, 12'b0});
				cor_x = CW'(ds_q);
			end
			tjlik_pkg::ST_MUL_RR: begin
				mul_start = !iss_q;
				mul_a = MW'(reach);
				mul_b = MW'(reach);
			end
			tjlik_pkg::ST_MUL_L22: begin
				mul_start = !iss_q;
				mul_a = MW'(l2);
				mul_b = MW'(l2);
			end
			tjlik_pkg::ST_MUL_L33: begin
				mul_start = !iss_q;
				mul_a = MW'(l3);
				mul_b = MW'(l3);
			end
			tjlik_pkg::ST_MUL_L23: begin
				mul_start = !iss_q;
				mul_a = MW'(l2);
				mul_b = MW'(l3);
			end
			tjlik_pkg::ST_SQ_A: begin
				sq_start = !iss_q;
				sq_rad = SQ_W'({dmn[34:0], 24'b0});
			end
			tjlik_pkg::ST_SQ_B: begin
				sq_start = !iss_q;
				sq_rad = SQ_W'({dpn[34:0], 24'b0});
			end
			tjlik_pkg::ST_AT_KNEE: begin
				cor_start = !iss_q;
				cor_y = CW'(sa_q);
				cor_x = CW'(sb_q);
			end
			tjlik_pkg::ST_AT_ALPHA: begin
				cor_start = !iss_q;
				cor_y = CW'(x_q) <<< 12;
				cor_x = CW'(ds_q);
			end
			tjlik_pkg::ST_MUL_SS: begin
				mul_start = !iss_q && (g2_q != '0);
				mul_a = MW'(sa_q);
				mul_b = MW'(sb_q);
			end
			tjlik_pkg::ST_AT_BETA: begin
				cor_start = !iss_q;
				cor_y = ss_q;
				cor_x = CW'({w_abs, 24'b0});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == tjlik_pkg::ST_IDLE && in_valid) begin
			x_q <= target_x;
			y_q <= target_y;
			z_q <= target_z;
		end
		if (mul_done) begin
			unique case (st_q)
				tjlik_pkg::ST_MUL_YY:  yy_q  <= prod[30:0];
				tjlik_pkg::ST_MUL_ZZ:  zz_q  <= prod[30:0];
				tjlik_pkg::ST_MUL_LL:  ll_q  <= prod[27:0];
				tjlik_pkg::ST_MUL_XX:  xx_q  <= prod[30:0];
				tjlik_pkg::ST_MUL_RR:  rr_q  <= prod[35:0];
				tjlik_pkg::ST_MUL_L22: l22_q <= prod[33:0];
				tjlik_pkg::ST_MUL_L33: l33_q <= prod[33:0];
				tjlik_pkg::ST_MUL_L23: l23_q <= prod[33:0];
				tjlik_pkg::ST_MUL_SS:  ss_q  <= prod[CW-1:0];
				default: ;
			endcase
		end
		if (sq_done) begin
			unique case (st_q)
				tjlik_pkg::ST_SQ_DS: ds_q <= root[27:0];
				tjlik_pkg::ST_SQ_A:  sa_q <= root;
				tjlik_pkg::ST_SQ_B:  sb_q <= root;
				default: ;
			endcase
		end
		if (cor_done) begin
			unique case (st_q)
				tjlik_pkg::ST_AT_YZ:    a1_q    <= cor_ang;
				tjlik_pkg::ST_AT_HIP:   t1_q    <= a1_q - cor_ang;
				tjlik_pkg::ST_AT_KNEE:  t3_q    <= cor_ang <<< 1;
				tjlik_pkg::ST_AT_ALPHA: alpha_q <= cor_ang;
				tjlik_pkg::ST_AT_BETA:  beta_q  <= cor_ang;
				default: ;
			endcase
		end
		unique case (st_q)
			tjlik_pkg::ST_CHECK: term1_q <= term1_c;
			tjlik_pkg::ST_G2:    g2_q <= g2_c;
			tjlik_pkg::ST_CLAMP: begin
				if (g2_q > 38'(rr_q))
					g2_q <= 38'(rr_q);
			end
			tjlik_pkg::ST_ND: begin
				d_q <= {l23_q, 1'b0};
				// cosine clamp
				if (n_raw > d_s)
					n_q <= 36'(d_s);
				else if (n_raw < -d_s)
					n_q <= 36'(-d_s);
				else
					n_q <= 36'(n_raw);
			end
			tjlik_pkg::ST_MUL_SS: begin
				if (g2_q == '0)
					beta_q <= tjlik_pkg::DEG90;
			end
			tjlik_pkg::ST_T2:  t2_q  <= tjlik_pkg::DEG90 - beta_q + alpha_q;
			tjlik_pkg::ST_THS: ths_q <= tjlik_pkg::DEG90 - t3_q + ofs256 + t2_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= tjlik_pkg::ST_IDLE;
			iss_q       <= 1'b0;
			ok_q        <= 1'b0;
			sol_q       <= 1'b0;
			out_valid_q <= 1'b0;
			hip_ofs_q   <= 14'd0;
			femur_len_q <= 14'd1600;
			tibia_len_q <= 14'd1600;
			tibia_ofs_q <= 15'sd0;
			hip_cen_q   <= 15'd5760;
			femur_cen_q <= 15'd5760;
			tibia_cen_q <= 15'd5760;
			corner_q    <= 2'd0;
			hs_srv_q    <= 16'sd5760;
			fm_srv_q    <= 16'sd5760;
			tb_srv_q    <= 16'sd5760;
			hs_jnt_q    <= 16'sd0;
			fm_jnt_q    <= 16'sd0;
			tb_jnt_q    <= 16'sd0;
		end else begin
			st_q <= st_d;
			if (st_q != st_d)
				iss_q <= 1'b0;
			else if (mul_start || sq_start || cor_start)
				iss_q <= 1'b1;

			if (st_q == tjlik_pkg::ST_CHECK)
				ok_q <= !term1_c[32];

			if (cfg_valid) begin
				unique case (tjlik_pkg::cfg_reg_t'(cfg_index))
					tjlik_pkg::REG_HIP_OFFSET:   hip_ofs_q   <= cfg_data[13:0];
					tjlik_pkg::REG_FEMUR_LEN:    femur_len_q <= cfg_data[13:0];
					tjlik_pkg::REG_TIBIA_LEN:    tibia_len_q <= cfg_data[13:0];
					tjlik_pkg::REG_TIBIA_OFS:    tibia_ofs_q <= cfg_data[14:0];
					tjlik_pkg::REG_HIP_CENTER:   hip_cen_q   <= cfg_data[14:0];
					tjlik_pkg::REG_FEMUR_CENTER: femur_cen_q <= cfg_data[14:0];
					tjlik_pkg::REG_TIBIA_CENTER: tibia_cen_q <= cfg_data[14:0];
					tjlik_pkg::REG_LEG_CORNER:   corner_q    <= cfg_data[1:0];
					default: ;
				endcase
			end

			if (out_fire) begin
				out_valid_q <= 1'b1;
				sol_q       <= ok_q;
				// impossible hip: keep the previous angles
				if (ok_q) begin
					hs_srv_q <= tjlik_pkg::to_out(cen_h + hs);
					hs_jnt_q <= tjlik_pkg::to_out(hs);
					if (left) begin
						fm_srv_q <= tjlik_pkg::to_out(cen_f - t2_q);
						tb_srv_q <= tjlik_pkg::to_out(cen_t - ths_q);
						fm_jnt_q <= tjlik_pkg::to_out(-t2_q);
						tb_jnt_q <= tjlik_pkg::to_out(tjlik_pkg::DEG180 - t3_q);
					end else begin
						fm_srv_q <= tjlik_pkg::to_out(cen_f + t2_q);
						tb_srv_q <= tjlik_pkg::to_out(cen_t + ths_q);
						fm_jnt_q <= tjlik_pkg::to_out(t2_q);
						tb_jnt_q <= tjlik_pkg::to_out(t3_q - tjlik_pkg::DEG180);
					end
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign solution_valid    = sol_q;
	assign hip_servo_angle   = hs_srv_q;
	assign femur_servo_angle = fm_srv_q;
	assign tibia_servo_angle = tb_srv_q;
	assign hip_joint_angle   = hs_jnt_q;
	assign femur_joint_angle = fm_jnt_q;
	assign tibia_joint_angle = tb_jnt_q;

endmodule

// ===== rtl/core/tjlik_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the leg inverse kinematics solver, bound to the top level.
module tjlik_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               solution_valid,
	input logic signed [15:0] hip_servo_angle,
	input logic signed [15:0] tibia_joint_angle
);

	logic signed [15:0] last_hip_q, last_tj_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_hip_q <= 16'sd5760;
			last_tj_q  <= 16'sd0;
		end else if (out_valid && out_ready) begin
			last_hip_q <= hip_servo_angle;
			last_tj_q  <= tibia_joint_angle;
		end
	end

	// one target at a time: drop ready right after a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a target is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(hip_servo_angle)))
		else $error("result beat dropped or changed while stalled");

	a_held_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !solution_valid) |->
			(hip_servo_angle == last_hip_q && tibia_joint_angle == last_tj_q))
		else $error("failed solution did not repeat the previous angles");

	// a new result is produced only after a target was taken
	a_no_result_without_work: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid)) |-> $past(!in_ready))
		else $error("result appeared with no target in work");

endmodule

bind three_joint_leg_inverse_kinematics tjlik_checker u_tjlik_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.solution_valid(solution_valid),
	.hip_servo_angle(hip_servo_angle),
	.tibia_joint_angle(tibia_joint_angle)
);

// ===== verif/three_joint_leg_inverse_kinematics_chk.sv =====
`timescale 1ns / 1ps
// Checker for the leg solver: watches the channels, predicts each angle set and compares.
module three_joint_leg_inverse_kinematics_chk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] target_x,
	input  logic signed [15:0] target_y,
	input  logic signed [15:0] target_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               solution_valid,
	input  logic signed [15:0] hip_servo_angle,
	input  logic signed [15:0] femur_servo_angle,
	input  logic signed [15:0] tibia_servo_angle,
	input  logic signed [15:0] hip_joint_angle,
	input  logic signed [15:0] femur_joint_angle,
	input  logic signed [15:0] tibia_joint_angle,
	output int                 fails,
	output int                 pending
);

	localparam longint QUARTER = 1474560;
	localparam longint HALF    = 2949120;
	localparam longint ROT_ANGLE [24] = '{
		737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
		3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0};

	typedef struct packed {
		logic              ok;
		logic signed [15:0] hs, fs, ts, hj, fj, tj;
	} angles_t;

	angles_t         angle_q[$];
	angles_t         held;
	logic [13:0]     offset_len, femur_len, tibia_len;
	logic signed [14:0] knee_ofs;
	logic [14:0]     hip_ctr, femur_ctr, tibia_ctr;
	logic [1:0]      corner;

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned absval(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint vec_angle(longint y, longint x);
		longint z, t, dx, dy;
		longint unsigned m;
		z = 0;
		if (y == 0 && x == 0) return 0;
		m = absval(y) > absval(x) ? absval(y) : absval(x);
		while (m >= (64'd1 << 30)) begin
			y = y >>> 1;
			x = x >>> 1;
			m >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			y = y * 2;
			x = x * 2;
			m <<= 1;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = QUARTER;
			end else begin
				x = -y; y = t; z = -QUARTER;
			end
		end
		for (int i = 0; i < tjlik_pkg::CORDIC_STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += ROT_ANGLE[i];
			end else begin
				x -= dx; y += dy; z -= ROT_ANGLE[i];
			end
		end
		return z;
	endfunction

	function automatic logic signed [15:0] round_sat(longint v);
		longint r;
		r = (v + 128) >>> 8;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic angles_t solve_leg(longint x, longint y, longint z);
		angles_t a;
		longint l1, l2, l3, plane, ds, t1, g2, reach, n, d, sa, sb, t3, alpha, beta, t2, ths, w, hs;
		logic left, front;
		a = held;
		a.ok = 1'b0;
		l1 = offset_len;
		l2 = 5 * longint'(femur_len);
		l3 = 5 * longint'(tibia_len);
		plane = y * y + z * z - l1 * l1;
		if (plane < 0) return a;
		ds = int_root(longint'(plane) << 24);
		t1 = vec_angle(y, z) - vec_angle(l1 * 4096, ds);
		g2 = 25 * (plane + x * x);
		reach = 5 * (longint'(femur_len) + longint'(tibia_len)) - 8;
		left = corner[1];
		front = corner[0];
		hs = (left == front) ? t1 : -t1;
		if (reach < 1) reach = 1;
		if (g2 > reach * reach) g2 = reach * reach;
		n = l2 * l2 + l3 * l3 - g2;
		d = 2 * l2 * l3;
		if (n > d) n = d;
		if (n < -d) n = -d;
		sa = int_root((d - n) << 24);
		sb = int_root((d + n) << 24);
		t3 = 2 * vec_angle(sa, sb);
		alpha = vec_angle(x * 4096, ds);
		if (g2 == 0)
			beta = QUARTER;
		else begin
			w = l2 * l2 + g2 - l3 * l3;
			if (w < 0) w = -w;
			beta = vec_angle(sa * sb, w * 16777216);
		end
		t2 = QUARTER - beta + alpha;
		ths = QUARTER - (t3 - longint'(knee_ofs) * 256) + t2;
		a.ok = 1'b1;
		a.hs = round_sat(longint'(hip_ctr) * 256 + hs);
		a.hj = round_sat(hs);
		if (left) begin
			a.fs = round_sat(longint'(femur_ctr) * 256 - t2);
			a.ts = round_sat(longint'(tibia_ctr) * 256 - ths);
			a.fj = round_sat(-t2);
			a.tj = round_sat(HALF - t3);
		end else begin
			a.fs = round_sat(longint'(femur_ctr) * 256 + t2);
			a.ts = round_sat(longint'(tibia_ctr) * 256 + ths);
			a.fj = round_sat(t2);
			a.tj = round_sat(t3 - HALF);
		end
		return a;
	endfunction

	task automatic compare(string name, logic signed [15:0] exp_v, logic signed [15:0] got);
		if (exp_v !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		angles_t e;
		if (!arst_n) begin
			offset_len <= '0;
			femur_len <= 14'd1600;
			tibia_len <= 14'd1600;
			knee_ofs <= '0;
			hip_ctr <= 15'd5760;
			femur_ctr <= 15'd5760;
			tibia_ctr <= 15'd5760;
			corner <= '0;
			held <= '{1'b0, 16'sd5760, 16'sd5760, 16'sd5760, 16'sd0, 16'sd0, 16'sd0};
			fails <= 0;
			pending <= 0;
			angle_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (tjlik_pkg::cfg_reg_t'(cfg_index))
					tjlik_pkg::REG_HIP_OFFSET:   offset_len <= cfg_data[13:0];
					tjlik_pkg::REG_FEMUR_LEN:    femur_len <= cfg_data[13:0];
					tjlik_pkg::REG_TIBIA_LEN:    tibia_len <= cfg_data[13:0];
					tjlik_pkg::REG_TIBIA_OFS:    knee_ofs <= cfg_data[14:0];
					tjlik_pkg::REG_HIP_CENTER:   hip_ctr <= cfg_data[14:0];
					tjlik_pkg::REG_FEMUR_CENTER: femur_ctr <= cfg_data[14:0];
					tjlik_pkg::REG_TIBIA_CENTER: tibia_ctr <= cfg_data[14:0];
					tjlik_pkg::REG_LEG_CORNER:   corner <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				e = solve_leg(longint'(target_x), longint'(target_y), longint'(target_z));
				if (e.ok) held <= e;
				angle_q.push_back(e);
			end
			if (out_valid && out_ready) begin
				if (angle_q.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual hip servo %0d",
						$time, hip_servo_angle);
					fails++;
				end else begin
					e = angle_q.pop_front();
					compare("solution_valid", 16'(e.ok), 16'(solution_valid));
					compare("hip_servo_angle", e.hs, hip_servo_angle);
					compare("femur_servo_angle", e.fs, femur_servo_angle);
					compare("tibia_servo_angle", e.ts, tibia_servo_angle);
					compare("hip_joint_angle", e.hj, hip_joint_angle);
					compare("femur_joint_angle", e.fj, femur_joint_angle);
					compare("tibia_joint_angle", e.tj, tibia_joint_angle);
				end
			end
			pending <= angle_q.size();
		end
	end

endmodule

// ===== verif/three_joint_leg_inverse_kinematics_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the leg solver: clock, reset, stimulus phases and the verdict.
module three_joint_leg_inverse_kinematics_tb;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0, cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0, in_ready;
	logic signed [15:0] target_x = '0, target_y = '0, target_z = '0;
	logic               out_valid, out_ready = 1'b0;
	logic               solution_valid;
	logic signed [15:0] hip_servo_angle, femur_servo_angle, tibia_servo_angle;
	logic signed [15:0] hip_joint_angle, femur_joint_angle, tibia_joint_angle;
	int                 fails, pending;
	bit                 steady = 1'b0;
	bit                 hold_req = 1'b0;

	always #5 clk = ~clk;

	three_joint_leg_inverse_kinematics dut (.*);
	three_joint_leg_inverse_kinematics_chk chk (.*);

	// result side: random stalls, quiet stretches, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_req = 1'b0;
			end
			out_ready <= steady || ($urandom_range(99) >= 35);
		end
	end

	// drop valid for a random gap now and then, except in steady phases
	task automatic gap();
		if (!steady && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
		bit acc;
		gap();
		in_valid <= 1'b1;
		target_x <= x;
		target_y <= y;
		target_z <= z;
		do begin
			@(negedge clk);
			acc = in_ready;
			@(posedge clk);
		end while (!acc);
	endtask

	task automatic write_reg(tjlik_pkg::cfg_reg_t idx, logic [15:0] val);
		bit acc;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			acc = cfg_ready;
			@(posedge clk);
		end while (!acc);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic setup(int l1, int l2, int l3, int ofs, int hc, int fc, int tc, int lc);
		write_reg(tjlik_pkg::REG_HIP_OFFSET, 16'(l1));
		write_reg(tjlik_pkg::REG_FEMUR_LEN, 16'(l2));
		write_reg(tjlik_pkg::REG_TIBIA_LEN, 16'(l3));
		write_reg(tjlik_pkg::REG_TIBIA_OFS, 16'(ofs));
		write_reg(tjlik_pkg::REG_HIP_CENTER, 16'(hc));
		write_reg(tjlik_pkg::REG_FEMUR_CENTER, 16'(fc));
		write_reg(tjlik_pkg::REG_TIBIA_CENTER, 16'(tc));
		write_reg(tjlik_pkg::REG_LEG_CORNER, 16'(lc));
		cfg_valid <= 1'b0;
	endtask

	// mostly targets around the working envelope, some full-range noise
	task automatic random_targets(int count, int span);
		int s;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 20)
				send(16'($urandom), 16'($urandom), 16'($urandom));
			else begin
				s = (span > 32000) ? 32000 : span;
				send(16'(int'($urandom_range(2 * s)) - s),
					16'(int'($urandom_range(2 * s)) - s),
					16'(-int'($urandom_range(s))));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, field extremes, zero vector, reach clamp
		send(0, 0, 0);
		send(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send(16'sh8000, 16'sh8000, 16'sh8000);
		send(0, 0, -3200);
		send(0, 0, -1000);
		send(500, -400, -2000);
		send(-900, 300, 2000);
		drain();
		// impossible hip with held angles, then exact offset distance
		setup(1000, 1200, 1400, -11520, 0, 23040, 23040, 3);
		send(0, 0, 0);
		send(0, 600, -700);
		send(0, 0, -1000);
		send(0, 1000, 0);
		send(800, 1000, -1500);
		drain();
		// zero-length links: tiny reach
		setup(0, 0, 0, 11520, 23040, 0, 0, 1);
		send(0, 0, 0);
		send(100, 200, -300);
		send(16'sh8000, 16'sh7fff, 0);
		drain();
		setup(16383, 16383, 16383, 0, 11520, 11520, 11520, 2);
		send(0, 16'sh7fff, 16'sh8000);
		send(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send(0, 0, 0);
		drain();

		// random phases across settings and corners
		for (int p = 0; p < 6; p++) begin
			setup($urandom_range(800), $urandom_range(800, 3000), $urandom_range(800, 3000),
				$urandom_range(23040) - 11520, $urandom_range(23040), $urandom_range(23040),
				$urandom_range(23040), p % 4);
			steady = (p == 2);
			if (p == 3) begin
				hold_req = 1'b1;
				random_targets(20, 4000);
				drain();
			end
			random_targets(110, 4000);
			drain();
		end
		steady = 1'b0;
		// raw register words exercise every data bit, including the masked ones
		for (int i = 0; i < 8; i++)
			write_reg(tjlik_pkg::cfg_reg_t'(i), 16'($urandom));
		write_reg(tjlik_pkg::REG_HIP_CENTER, 16'hffff);
		write_reg(tjlik_pkg::REG_FEMUR_LEN, 16'h0000);
		cfg_valid <= 1'b0;
		random_targets(40, 32000);
		drain();
		setup(16383, 16383, 16383, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
		random_targets(40, 32000);
		drain();

		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#30ms;
		$display("Verification failed");
		$finish;
	end

endmodule
